>>> design/abwcd_pkg.sv
// Package for the alarm beeper with confirmation delay.
// Holds the transaction payload types, level codes and register map.
// No dependencies; every other file imports it.
`default_nettype none

package abwcd_pkg;

    // Level codes
    localparam logic [1:0] LEVEL_SAFE    = 2'd0;
    localparam logic [1:0] LEVEL_WARNING = 2'd1;
    localparam logic [1:0] LEVEL_DANGER  = 2'd2;

    // Request kinds
    localparam logic REQ_TICK      = 1'b0;
    localparam logic REQ_SET_LEVEL = 1'b1;

    // Register map
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int CONFIRM_TICKS_W = 20;
    localparam int PHASE_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_TICKS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WARNING_ON_TICKS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WARNING_OFF_TICKS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DANGER_ON_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DANGER_OFF_TICKS  = 3'd4;

    // Register reset values
    localparam logic [CONFIRM_TICKS_W-1:0] CONFIRM_TICKS_RST     = 20'd30000;
    localparam logic [PHASE_W-1:0]         WARNING_ON_TICKS_RST  = 16'd200;
    localparam logic [PHASE_W-1:0]         WARNING_OFF_TICKS_RST = 16'd800;
    localparam logic [PHASE_W-1:0]         DANGER_ON_TICKS_RST   = 16'd100;
    localparam logic [PHASE_W-1:0]         DANGER_OFF_TICKS_RST  = 16'd100;

    typedef struct packed {
        logic       req_type;
        logic [1:0] new_level;
    } t_in_item;

    typedef struct packed {
        logic       tone_enable;
        logic       alarm_pending;
        logic       alarm_sounding;
        logic [1:0] current_level;
    } t_out_item;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

endpackage

`default_nettype wire

>>> design/abwcd_if.sv
// Valid/ready channel interfaces for the alarm beeper: input items,
// result items and configuration writes. Depends on abwcd_pkg.
`default_nettype none

interface abwcd_in_if;
    import abwcd_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface abwcd_out_if;
    import abwcd_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface abwcd_cfg_if;
    import abwcd_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/alarm_beeper_with_confirm_delay.sv
// Alarm beeper with confirmation delay, top level.
// Depends on abwcd_pkg and the channel interfaces in abwcd_if.sv.
//
// Each input transaction is either a one-millisecond tick or a request to
// set a new alarm level (safe, warning, danger; code three counts as safe).
// Leaving safe arms a confirmation wait with the tone off; going back to
// safe cancels everything at once. After confirm_ticks ticks the alarm is
// confirmed and beeping starts with an off phase, then alternates on and
// off phases whose lengths come from the warning or danger registers.
// Swapping warning and danger while beeping restarts the pattern with the
// tone off. Both counters saturate at all ones. Every input transaction
// yields exactly one result transaction carrying the state after the
// update. Throughput is one transaction per clock while the result is not
// stalled; each one passes the input register, then the result register
// that also commits the state. The combinational state update between
// those two registers sets that rate. Configuration writes are always
// accepted and must only be issued while no transaction is in flight.
`default_nettype none

module alarm_beeper_with_confirm_delay #(
    parameter int CONFIRM_WIDTH = 20
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    abwcd_in_if.sink    i_in,
    abwcd_out_if.source o_out,
    abwcd_cfg_if.sink   i_cfg
);
    import abwcd_pkg::*;

    // Compare width wide enough for both the counter and the register
    localparam int CMP_W = (CONFIRM_WIDTH > CONFIRM_TICKS_W) ? CONFIRM_WIDTH : CONFIRM_TICKS_W;

    // Configuration registers
    logic [CONFIRM_TICKS_W-1:0] r_confirm_ticks;
    logic [PHASE_W-1:0]         r_warning_on_ticks;
    logic [PHASE_W-1:0]         r_warning_off_ticks;
    logic [PHASE_W-1:0]         r_danger_on_ticks;
    logic [PHASE_W-1:0]         r_danger_off_ticks;

    // Alarm state
    logic [1:0]               r_level,   n_level;
    logic                     r_pending, n_pending;
    logic                     r_sounding, n_sounding;
    logic                     r_tone,    n_tone;
    logic [CONFIRM_WIDTH-1:0] r_confirm_elapsed, n_confirm_elapsed;
    logic [PHASE_W-1:0]       r_phase_elapsed,   n_phase_elapsed;

    // Input stage and result stage
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic out_free;
    logic s1_free;
    logic s1_fire;

    // Result register can take a new transaction when empty or draining
    assign out_free = !r_out_valid || o_out.ready;
    // Input register can take a new transaction when empty or moving on
    assign s1_free  = !r_s1_valid || out_free;
    assign s1_fire  = r_s1_valid && out_free;

    assign i_in.ready  = s1_free;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;
    assign i_cfg.ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_ticks     <= CONFIRM_TICKS_RST;
            r_warning_on_ticks  <= WARNING_ON_TICKS_RST;
            r_warning_off_ticks <= WARNING_OFF_TICKS_RST;
            r_danger_on_ticks   <= DANGER_ON_TICKS_RST;
            r_danger_off_ticks  <= DANGER_OFF_TICKS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                REG_CONFIRM_TICKS:     r_confirm_ticks     <= i_cfg.data.data;
                REG_WARNING_ON_TICKS:  r_warning_on_ticks  <= i_cfg.data.data[PHASE_W-1:0];
                REG_WARNING_OFF_TICKS: r_warning_off_ticks <= i_cfg.data.data[PHASE_W-1:0];
                REG_DANGER_ON_TICKS:   r_danger_on_ticks   <= i_cfg.data.data[PHASE_W-1:0];
                REG_DANGER_OFF_TICKS:  r_danger_off_ticks  <= i_cfg.data.data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Next-state logic for the transaction held in the input register
    logic [1:0]               req_level;
    logic [CONFIRM_WIDTH-1:0] confirm_inc;
    logic [PHASE_W-1:0]       phase_inc;
    logic [PHASE_W-1:0]       on_len;
    logic [PHASE_W-1:0]       off_len;
    logic [PHASE_W-1:0]       limit;
    logic                     confirm_done;

    always_comb begin
        // Level code three maps to safe
        req_level = ((r_s1_item.new_level == LEVEL_WARNING) ||
                     (r_s1_item.new_level == LEVEL_DANGER)) ? r_s1_item.new_level : LEVEL_SAFE;

        confirm_inc = (r_confirm_elapsed == {CONFIRM_WIDTH{1'b1}}) ?
                      r_confirm_elapsed : r_confirm_elapsed + CONFIRM_WIDTH'(1);
        phase_inc   = (r_phase_elapsed == {PHASE_W{1'b1}}) ?
                      r_phase_elapsed : r_phase_elapsed + PHASE_W'(1);
        confirm_done = CMP_W'(confirm_inc) >= CMP_W'(r_confirm_ticks);

        on_len  = (r_level == LEVEL_DANGER) ? r_danger_on_ticks  : r_warning_on_ticks;
        off_len = (r_level == LEVEL_DANGER) ? r_danger_off_ticks : r_warning_off_ticks;
        limit   = r_tone ? on_len : off_len;

        n_level           = r_level;
        n_pending         = r_pending;
        n_sounding        = r_sounding;
        n_tone            = r_tone;
        n_confirm_elapsed = r_confirm_elapsed;
        n_phase_elapsed   = r_phase_elapsed;

        if (r_s1_item.req_type == REQ_TICK) begin
            if (r_level == LEVEL_SAFE) begin
                n_tone = 1'b0;
            end else if (r_pending) begin
                n_confirm_elapsed = confirm_inc;
                if (confirm_done) begin
                    // Confirm: start with an off phase, zero length flips at once
                    n_pending       = 1'b0;
                    n_sounding      = 1'b1;
                    n_phase_elapsed = '0;
                    n_tone          = (off_len == '0);
                end
            end else if (r_sounding) begin
                if (phase_inc >= limit) begin
                    n_tone          = !r_tone;
                    n_phase_elapsed = '0;
                end else begin
                    n_phase_elapsed = phase_inc;
                end
            end
        end else if (req_level != r_level) begin
            n_level = req_level;
            if (req_level == LEVEL_SAFE) begin
                n_pending  = 1'b0;
                n_sounding = 1'b0;
                n_tone     = 1'b0;
            end else if (r_level == LEVEL_SAFE) begin
                n_pending         = 1'b1;
                n_sounding        = 1'b0;
                n_tone            = 1'b0;
                n_confirm_elapsed = '0;
            end else if (r_sounding) begin
                // Warning/danger swap while beeping: restart silent
                n_phase_elapsed = '0;
                n_tone          = 1'b0;
            end
        end
    end

    // Control state and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level           <= LEVEL_SAFE;
            r_pending         <= 1'b0;
            r_sounding        <= 1'b0;
            r_tone            <= 1'b0;
            r_confirm_elapsed <= '0;
            r_phase_elapsed   <= '0;
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in.valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            // Commit the state as the transaction moves to the result stage
            if (s1_fire) begin
                r_level           <= n_level;
                r_pending         <= n_pending;
                r_sounding        <= n_sounding;
                r_tone            <= n_tone;
                r_confirm_elapsed <= n_confirm_elapsed;
                r_phase_elapsed   <= n_phase_elapsed;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s1_free && i_in.valid) begin
            r_s1_item <= i_in.data;
        end
        if (s1_fire) begin
            r_out_item.tone_enable    <= n_tone;
            r_out_item.alarm_pending  <= n_pending;
            r_out_item.alarm_sounding <= n_sounding;
            r_out_item.current_level  <= n_level;
        end
    end

endmodule

`default_nettype wire
